/* hw/rtl/mcfb_pkg.sv */
package mcfb_pkg;

	localparam logic [7:0] HDR_A     = 8'd183;
	localparam logic [7:0] HDR_B     = 8'd184;
	localparam logic [7:0] CMD_POS   = 8'd220;
	localparam logic [7:0] CMD_SPEED = 8'd130;
	localparam logic [7:0] CMD_STATE = 8'd10;
	localparam logic [7:0] LEN_POS   = 8'd6;
	localparam logic [7:0] LEN_SPEED = 8'd2;
	localparam logic [7:0] LEN_STATE = 8'd1;
	localparam logic [7:0] STATE_OPEN = 8'd5;
	localparam logic [7:0] POS_TAIL  = 8'd130;

	localparam int QDEPTH = 2;
	localparam int IDXW   = 4;

	typedef enum logic [1:0] {
		OP_POS   = 2'd0,
		OP_SPEED = 2'd1,
		OP_STATE = 2'd2
	} op_t;

	// one classified request waiting for the serializer
	typedef struct packed {
		op_t         kind;
		logic [7:0]  device_id;
		logic [31:0] value;
		logic [7:0]  chk;
	} desc_t;

	// index of the checksum byte
	function automatic logic [IDXW-1:0] last_idx(input op_t kind);
		logic [IDXW-1:0] r;
		unique case (kind)
			OP_POS:   r = IDXW'(11);
			OP_SPEED: r = IDXW'(7);
			OP_STATE: r = IDXW'(6);
			default:  r = IDXW'(6);
		endcase
		return r;
	endfunction

	function automatic logic [7:0] frame_byte(input desc_t d, input logic [IDXW-1:0] idx);
		logic [7:0] b;
		b = 8'd0;
		if (idx == last_idx(d.kind)) begin
			b = d.chk;
		end else begin
			unique case (idx)
				IDXW'(0): b = HDR_A;
				IDXW'(1): b = HDR_B;
				IDXW'(2): b = d.device_id;
				IDXW'(3): b = (d.kind == OP_POS) ? CMD_POS :
					(d.kind == OP_SPEED) ? CMD_SPEED : CMD_STATE;
				IDXW'(4): b = (d.kind == OP_POS) ? LEN_POS :
					(d.kind == OP_SPEED) ? LEN_SPEED : LEN_STATE;
				IDXW'(5): b = (d.kind == OP_STATE) ? STATE_OPEN : d.value[7:0];
				IDXW'(6): b = d.value[15:8];
				IDXW'(7): b = d.value[23:16];
				IDXW'(8): b = d.value[31:24];
				IDXW'(9): b = POS_TAIL;
				default:  b = 8'd0;
			endcase
		end
		return b;
	endfunction

endpackage

/* hw/rtl/motor_command_frame_builder_core.sv */
// Turns each command request into a serial motor-driver frame, one byte per cycle on the
// master side unless m_tready stalls it, with tlast on the closing checksum byte: a position
// frame is 12 bytes, a speed frame 8 and a state-open frame 7, all sent by the single byte
// serializer in mcfb_back. The front end classifies requests and precomputes the
// checksum, and a two-entry queue holds the frame being sent plus one further request, so the
// next frame starts right after the checksum byte of the current one; requests with opcode 3
// are accepted and produce no frame.
module motor_command_frame_builder_core import mcfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // device_id[7:0], value[39:8]
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // frame_byte[7:0]
	output logic        m_tlast
);

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	desc_t push_desc;
	desc_t head;

	mcfb_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	mcfb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	mcfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (m_tvalid && m_tlast))
		else $error("queue pop without checksum byte issued");

	a_idle_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(q_empty && (m_tready || !m_tvalid)) |=> !m_tvalid)
		else $error("byte issued with nothing queued");

endmodule

/* hw/rtl/mcfb_front.sv */
module mcfb_front import mcfb_pkg::*; (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        push,
	output desc_t       push_desc
);

	logic       known;
	op_t        kind;
	logic [7:0] sum;
	logic [7:0] id;
	logic [31:0] v;

	assign id = s_tdata[7:0];
	assign v  = s_tdata[39:8];

	always_comb begin
		known = 1'b1;
		kind  = OP_POS;
		unique case (s_tuser)
			2'd0:    kind = OP_POS;
			2'd1:    kind = OP_SPEED;
			2'd2:    kind = OP_STATE;
			default: known = 1'b0;
		endcase
	end

	// byte sum of everything before the checksum
	always_comb begin
		sum = 8'(HDR_A + HDR_B + id);
		unique case (kind)
			OP_POS: sum = 8'(sum + CMD_POS + LEN_POS + v[7:0] + v[15:8] + v[23:16]
				+ v[31:24] + POS_TAIL);
			OP_SPEED: sum = 8'(sum + CMD_SPEED + LEN_SPEED + v[7:0] + v[15:8]);
			OP_STATE: sum = 8'(sum + CMD_STATE + LEN_STATE + STATE_OPEN);
			default:  sum = 8'(sum);
		endcase
	end

	assign s_tready            = !q_full;
	// unknown opcodes are taken and dropped
	assign push                = s_tvalid && !q_full && known;
	assign push_desc.kind      = kind;
	assign push_desc.device_id = id;
	assign push_desc.value     = v;
	assign push_desc.chk       = 8'(8'd0 - sum);

endmodule

/* hw/rtl/mcfb_queue.sv */
module mcfb_queue import mcfb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output desc_t head
);

	localparam int PW = $clog2(QDEPTH);

	desc_t             mem [QDEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= (PW+1)'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= (PW+1)'(cnt_q - 1'b1);
			end
		end
	end

endmodule

/* hw/rtl/mcfb_back.sv */
module mcfb_back import mcfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  desc_t      head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [IDXW-1:0] idx_q;
	logic            m_tvalid_q;
	logic [7:0]      m_tdata_q;
	logic            m_tlast_q;
	logic            load;
	logic            issue;
	logic            at_last;

	assign load    = !m_tvalid_q || m_tready;
	assign issue   = load && !q_empty;
	assign at_last = (idx_q == last_idx(head.kind));
	// the head leaves the queue as its checksum byte is issued
	assign pop     = issue && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= !q_empty;
			if (issue) begin
				idx_q <= at_last ? '0 : IDXW'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			m_tdata_q <= frame_byte(head, idx_q);
			m_tlast_q <= at_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* tb/motor_command_frame_builder_core_tb.sv */
module motor_command_frame_builder_core_tb import mcfb_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SETTLE      = 40;
	localparam int         MAX_REPORTS = 10;
	localparam int         PHASE_ITEMS = 31;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	frame_byte_t pending_bytes[$];
	int          mismatches  = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	motor_command_frame_builder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// builds the whole frame for one command request and queues its bytes
	function automatic void queue_frame(logic [1:0] opcode, logic [7:0] id, logic [31:0] val);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		frame_byte_t fb;
		bytes = {HDR_A, HDR_B, id};
		case (opcode)
			OP_POS: begin
				bytes = {bytes, CMD_POS, LEN_POS, val[7:0], val[15:8], val[23:16], val[31:24],
					POS_TAIL, 8'h00};
			end
			OP_SPEED: begin
				bytes = {bytes, CMD_SPEED, LEN_SPEED, val[7:0], val[15:8]};
			end
			OP_STATE: begin
				bytes = {bytes, CMD_STATE, LEN_STATE, STATE_OPEN};
			end
			default: begin
				return;
			end
		endcase
		sum = 8'h00;
		foreach (bytes[i]) begin
			sum += bytes[i];
			fb.data = bytes[i];
			fb.last = 1'b0;
			pending_bytes.push_back(fb);
		end
		fb.data = 8'h00 - sum;
		fb.last = 1'b1;
		pending_bytes.push_back(fb);
	endfunction

	// prediction and comparison share one process so acceptance order is fixed
	always @(posedge clk) begin
		frame_byte_t want;
		if (arst_n && s_tvalid && s_tready) begin
			queue_frame(s_tuser, s_tdata[7:0], s_tdata[39:8]);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("unexpected frame byte %0d last %0b", m_tdata, m_tlast);
				end
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("frame byte mismatch: wanted %0d last %0b, got %0d last %0b",
							want.data, want.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_command(logic [1:0] opcode, logic [7:0] id, logic [31:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= opcode;
		s_tdata  <= {val, id};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_random_command();
		logic [1:0]  opcode;
		logic [31:0] val;
		opcode = ($urandom_range(9) == 0) ? OP_UNUSED : 2'($urandom_range(2));
		case ($urandom_range(7))
			0: val = 32'h0000_0000;
			1: val = 32'hffff_ffff;
			2: val = 32'h8000_0000 | $urandom_range(255);
			default: val = $urandom;
		endcase
		send_command(opcode, 8'($urandom_range(255)), val);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic test_directed_frames();
		send_command(OP_POS,   8'd0,   32'h0000_0000);
		send_command(OP_POS,   8'd255, 32'hffff_ffff);
		send_command(OP_POS,   8'd1,   32'h8000_0000);
		send_command(OP_POS,   8'd128, 32'h7fff_ffff);
		send_command(OP_POS,   8'd77,  32'h1234_5678);
		send_command(OP_SPEED, 8'd0,   32'h0000_0000);
		send_command(OP_SPEED, 8'd255, 32'h0000_ffff);
		// upper half of the value is dropped in a speed frame
		send_command(OP_SPEED, 8'd42,  32'hdead_0001);
		send_command(OP_SPEED, 8'd3,   32'h8000_8000);
		send_command(OP_STATE, 8'd0,   32'h0000_0000);
		send_command(OP_STATE, 8'd255, 32'hffff_ffff);
		// byte sums that wrap to zero give a zero checksum
		send_command(OP_STATE, 8'd129, 32'h5a5a_5a5a);
		send_command(OP_SPEED, 8'd0,   32'h0000_000d);
		send_command(OP_UNUSED, 8'd255, 32'hffff_ffff);
		send_command(OP_UNUSED, 8'd0,  32'h0000_0000);
		send_command(OP_POS,   8'd9,   32'h0102_0304);
		send_command(OP_UNUSED, 8'd17, 32'h8000_0000);
		send_command(OP_STATE, 8'd18,  32'h0000_0000);
		wait_drained();
	endtask

	task automatic test_random_back_to_back();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS) send_random_command();
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct  = 79;
		recv_stall_pct = 0;
		repeat (PHASE_ITEMS) send_random_command();
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 79;
		repeat (PHASE_ITEMS) send_random_command();
	endtask

	task automatic test_random_both_idle();
		send_idle_pct  = 25;
		recv_stall_pct = 25;
		repeat (PHASE_ITEMS) send_random_command();
	endtask

	// sender holds off until the output side has emptied, then restarts
	task automatic test_pause_until_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 25;
		repeat (4) send_random_command();
		wait_drained();
		@(negedge clk);
		repeat (4) send_random_command();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_frames();
		test_random_back_to_back();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();
		test_pause_until_drained();
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
